// ===== rtl/slmc_pkg.sv =====
// Shared types, constants and the sine table of the status LED mode controller.
`default_nettype none

package slmc_pkg;

  localparam int unsigned NOW_W     = 32;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned BR_W      = 13;
  localparam int unsigned HALF_W    = 10;
  localparam int unsigned DIST_W    = 14;
  localparam int unsigned CFG_IDX_W = 3;

  // Serial multiplier operand widths
  localparam int unsigned MUL_AW = 16;
  localparam int unsigned MUL_BW = 13;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  localparam int unsigned BREATH_PERIOD_MS_DEF = 3000;

  localparam logic [NOW_W-1:0]  FLASH_MS      = NOW_W'(300);
  localparam logic [HALF_W-1:0] HALF_MAX      = HALF_W'(600);
  localparam logic [HALF_W-1:0] HALF_MIN      = HALF_W'(50);
  localparam logic [DIST_W-1:0] NEAR_START_Q4 = DIST_W'(4800);
  localparam logic [12:0]       NEAR_SPAN_Q4  = 13'd3200;
  localparam logic [15:0]       SINE_MID      = 16'h8000;
  localparam logic [MUL_BW-1:0] BR_GAIN       = MUL_BW'(3277);  // 0.1 in Q1.15
  localparam logic [BR_W-1:0]   BR_BASE       = BR_W'(1638);    // 0.15 - 0.1 in Q1.15

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_FLASH = 2'd1;
  localparam logic [1:0] OP_RADAR = 2'd2;

  // Radar levels
  localparam logic [1:0] LVL_NEAR  = 2'd1;
  localparam logic [1:0] LVL_CLOSE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_RED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_GREEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_BLUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_RED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_BLUE  = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FLASH = 2'd1,
    MODE_NEAR  = 2'd2,
    MODE_CLOSE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BRT,
    ST_CHAN,
    ST_GAMMA,
    ST_EMIT
  } state_t;

  // Quarter-wave sine, round(32768*sin(k*pi/32)), top entry held at 32767
  function automatic logic [15:0] sine_rom(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3212;
      5'd2:    v = 16'd6393;
      5'd3:    v = 16'd9512;
      5'd4:    v = 16'd12540;
      5'd5:    v = 16'd15447;
      5'd6:    v = 16'd18205;
      5'd7:    v = 16'd20788;
      5'd8:    v = 16'd23170;
      5'd9:    v = 16'd25330;
      5'd10:   v = 16'd27246;
      5'd11:   v = 16'd28899;
      5'd12:   v = 16'd30274;
      5'd13:   v = 16'd31357;
      5'd14:   v = 16'd32138;
      5'd15:   v = 16'd32610;
      5'd16:   v = 16'd32767;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/slmc_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module slmc_mul (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [slmc_pkg::MUL_AW-1:0] a,
  input  wire logic [slmc_pkg::MUL_BW-1:0] b,
  output logic                           done,
  output logic [slmc_pkg::MUL_PW-1:0]    prod
);

  localparam int unsigned AW = slmc_pkg::MUL_AW;
  localparam int unsigned BW = slmc_pkg::MUL_BW;
  localparam int unsigned PW = slmc_pkg::MUL_PW;
  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW-1:0] mcand;
  logic [CW-1:0] cnt;
  logic [AW-1:0] addend;
  logic [AW:0]   sum;

  always_comb begin
    addend = prod[0] ? mcand : '0;
    sum    = {1'b0, prod[PW-1:BW]} + {1'b0, addend};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt   <= CW'(BW);
        mcand <= a;
        prod  <= {{AW{1'b0}}, b};
      end else if (cnt != '0) begin
        // add on the low multiplier bit, shift the partial product right
        prod <= {sum, prod[BW-1:1]};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slmc_div.sv =====
// Restoring serial divider by the breathing period: phase index of the time stamp.
`default_nettype none

module slmc_div #(
  parameter int unsigned PERIOD = slmc_pkg::BREATH_PERIOD_MS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [slmc_pkg::NOW_W-1:0]     dividend,
  output logic                                done,
  output logic [slmc_pkg::IDX_W-1:0]          idx
);

  localparam int unsigned DW    = slmc_pkg::NOW_W;
  localparam int unsigned IW    = slmc_pkg::IDX_W;
  localparam int unsigned RW    = $clog2(PERIOD + 1);
  localparam int unsigned STEPS = DW + IW;
  localparam int unsigned CW    = $clog2(STEPS + 1);
  localparam logic [RW:0] DIVISOR = (RW + 1)'(PERIOD);

  logic [RW-1:0] rem;
  logic [DW-1:0] num;
  logic [CW-1:0] cnt;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          fits;

  always_comb begin
    trial = {rem, num[DW-1]};
    fits  = (trial >= DIVISOR);
    diff  = trial - DIVISOR;
  end

  // First DW steps leave now mod PERIOD in rem, the last IW steps
  // shift in zeros and yield floor(rem * 2^IW / PERIOD).
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(STEPS);
        rem <= '0;
        num <= dividend;
      end else if (cnt != '0) begin
        rem <= fits ? diff[RW-1:0] : trial[RW-1:0];
        num <= {num[DW-2:0], 1'b0};
        idx <= {idx[IW-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/status_led_mode_controller.sv =====
// Status LED mode controller: a tick of 1 ms time yields one gamma-corrected
// RGB duty item from the current mode (idle breathing, flash, near blink or
// close); a tick that expires a flash yields none. Flash requests and radar
// updates change the mode and yield nothing. One item is handled at a time.
// Flash requests, radar updates, unused operations and an expiring flash are
// done when they are accepted; a tick in flash, near or close mode runs one
// 13-step serial squaring per channel, three lanes side by side; a tick in
// idle mode runs the 38-step serial divider that reduces the time stamp by
// the breathing period and three 13-step rounds of the shift-add multipliers
// (brightness, channel scaling, gamma). A tick waits in its emit state while
// the previous item still sits unread in the output register. A finished
// item waits in the output register while the next input item is taken.
`default_nettype none

module status_led_mode_controller #(
  parameter int unsigned BREATH_PERIOD_MS = slmc_pkg::BREATH_PERIOD_MS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // cfg: node_red, node_green, node_blue, alert_red, alert_green, alert_blue
  input  wire logic                             cfg_we,
  input  wire logic [slmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [slmc_pkg::CH_W-1:0]        cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // tdata: now_ms[31:0], flash_red[39:32], flash_green[47:40],
  //        flash_blue[55:48], radar_level[57:56], distance_q4[71:58]
  input  wire logic [71:0]                      s_tdata,
  // tuser: operation[1:0]
  input  wire logic [1:0]                       s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // tdata: duty_red[7:0], duty_green[15:8], duty_blue[23:16]
  output logic [23:0]                           m_tdata
);

  localparam int unsigned NOW_W  = slmc_pkg::NOW_W;
  localparam int unsigned CH_W   = slmc_pkg::CH_W;
  localparam int unsigned NUM_CH = slmc_pkg::NUM_CH;
  localparam int unsigned BR_W   = slmc_pkg::BR_W;
  localparam int unsigned HALF_W = slmc_pkg::HALF_W;
  localparam int unsigned DIST_W = slmc_pkg::DIST_W;
  localparam int unsigned AW     = slmc_pkg::MUL_AW;
  localparam int unsigned BW     = slmc_pkg::MUL_BW;
  localparam int unsigned PW     = slmc_pkg::MUL_PW;

  // Input fields
  logic [1:0]        op;
  logic [NOW_W-1:0]  now;
  logic [CH_W-1:0]   in_rgb [NUM_CH];
  logic [1:0]        level;
  logic [DIST_W-1:0] distance;

  assign op        = s_tuser;
  assign now       = s_tdata[31:0];
  assign in_rgb[0] = s_tdata[39:32];
  assign in_rgb[1] = s_tdata[47:40];
  assign in_rgb[2] = s_tdata[55:48];
  assign level     = s_tdata[57:56];
  assign distance  = s_tdata[71:58];

  // Configuration registers
  logic [CH_W-1:0] node_rgb  [NUM_CH];
  logic [CH_W-1:0] alert_rgb [NUM_CH];

  // Mode state
  slmc_pkg::mode_t   mode;
  logic [NOW_W-1:0]  flash_start;
  logic [CH_W-1:0]   flash_rgb [NUM_CH];
  logic [NOW_W-1:0]  blink_last;
  logic              blink_on;
  logic [HALF_W-1:0] half;

  // Sequencer
  slmc_pkg::state_t state;
  slmc_pkg::state_t state_next;
  logic             launch;
  logic             s_accept;
  logic             tick;
  logic             out_load;

  // Datapath
  logic [CH_W-1:0]   v      [NUM_CH];
  logic [CH_W-1:0]   duty   [NUM_CH];
  logic [BR_W-1:0]   br;
  logic              div_start;
  logic              div_done;
  logic [slmc_pkg::IDX_W-1:0] idx;
  logic [AW-1:0]     mul_a    [NUM_CH];
  logic [BW-1:0]     mul_b    [NUM_CH];
  logic [PW-1:0]     mul_prod [NUM_CH];
  logic [NUM_CH-1:0] mul_done;
  logic              mul_start;
  logic              mul_all_done;

  // Tick decisions
  logic [NOW_W-1:0]  flash_elapsed;
  logic              flash_expired;
  logic [NOW_W-1:0]  blink_elapsed;
  logic              blink_on_new;
  logic [12:0]       near_raw;
  logic [11:0]       near_x;
  logic [15:0]       near_scaled;
  logic [HALF_W-1:0] half_new;

  // Breathing brightness
  logic [15:0] mag;
  logic [15:0] biased;
  logic [16:0] gsum [NUM_CH];

  assign s_accept     = s_tvalid && s_tready;
  assign tick         = s_accept && (op == slmc_pkg::OP_TICK);
  assign div_start    = tick && (mode == slmc_pkg::MODE_IDLE);
  assign mul_all_done = &mul_done;

  always_comb begin
    flash_elapsed = now - flash_start;
    flash_expired = (flash_elapsed >= slmc_pkg::FLASH_MS);
    blink_elapsed = now - blink_last;
    blink_on_new  = (blink_elapsed >= NOW_W'(half)) ? !blink_on : blink_on;

    // half = 600 - ceil(x * 11 / 64), x the clamped approach in Q4 cm
    near_raw    = (distance >= slmc_pkg::NEAR_START_Q4) ? 13'd0
                                                    : 13'(slmc_pkg::NEAR_START_Q4 - distance);
    near_x      = (near_raw > slmc_pkg::NEAR_SPAN_Q4) ? 12'(slmc_pkg::NEAR_SPAN_Q4)
                                                      : near_raw[11:0];
    near_scaled = {1'b0, near_x, 3'b000} + {3'b000, near_x, 1'b0} + {4'b0000, near_x}
                  + 16'd63;
    half_new    = slmc_pkg::HALF_MAX - near_scaled[15:6];

    // Quadrant of the sine from the phase index
    mag    = idx[4] ? slmc_pkg::sine_rom(5'd16 - {1'b0, idx[3:0]})
                    : slmc_pkg::sine_rom({1'b0, idx[3:0]});
    biased = idx[5] ? (slmc_pkg::SINE_MID - mag) : (slmc_pkg::SINE_MID + mag);

    // floor(sq / 255) for a 16-bit square
    for (int i = 0; i < NUM_CH; i++) begin
      gsum[i] = {1'b0, mul_prod[i][15:0]} + {9'd0, mul_prod[i][15:8]} + 17'd1;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_rgb[0]  <= 8'd0;
      node_rgb[1]  <= 8'd255;
      node_rgb[2]  <= 8'd128;
      alert_rgb[0] <= 8'd255;
      alert_rgb[1] <= 8'd0;
      alert_rgb[2] <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slmc_pkg::REG_NODE_RED:    node_rgb[0]  <= cfg_data;
        slmc_pkg::REG_NODE_GREEN:  node_rgb[1]  <= cfg_data;
        slmc_pkg::REG_NODE_BLUE:   node_rgb[2]  <= cfg_data;
        slmc_pkg::REG_ALERT_RED:   alert_rgb[0] <= cfg_data;
        slmc_pkg::REG_ALERT_GREEN: alert_rgb[1] <= cfg_data;
        slmc_pkg::REG_ALERT_BLUE:  alert_rgb[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mode updates happen at the accept edge
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= slmc_pkg::MODE_IDLE;
      flash_start  <= '0;
      flash_rgb[0] <= 8'd0;
      flash_rgb[1] <= 8'd255;
      flash_rgb[2] <= 8'd128;
      blink_last   <= '0;
      blink_on     <= 1'b0;
      half         <= slmc_pkg::HALF_MAX;
    end else if (s_accept) begin
      case (op)
        slmc_pkg::OP_FLASH: begin
          if (mode == slmc_pkg::MODE_IDLE || mode == slmc_pkg::MODE_FLASH) begin
            flash_rgb   <= in_rgb;
            flash_start <= now;
            mode        <= slmc_pkg::MODE_FLASH;
          end
        end
        slmc_pkg::OP_RADAR: begin
          if (level == slmc_pkg::LVL_CLOSE) begin
            mode <= slmc_pkg::MODE_CLOSE;
          end else if (level == slmc_pkg::LVL_NEAR) begin
            if (mode != slmc_pkg::MODE_NEAR) begin
              blink_last <= now;
              blink_on   <= 1'b1;
              mode       <= slmc_pkg::MODE_NEAR;
            end
            half <= half_new;
          end else if (mode == slmc_pkg::MODE_NEAR || mode == slmc_pkg::MODE_CLOSE) begin
            mode <= slmc_pkg::MODE_IDLE;
          end
        end
        slmc_pkg::OP_TICK: begin
          if (mode == slmc_pkg::MODE_NEAR && blink_on_new != blink_on) begin
            blink_on   <= blink_on_new;
            blink_last <= now;
          end
          if (mode == slmc_pkg::MODE_FLASH && flash_expired) begin
            mode <= slmc_pkg::MODE_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Channel values, brightness and duties
  always_ff @(posedge clk) begin
    if (tick) begin
      for (int i = 0; i < NUM_CH; i++) begin
        case (mode)
          slmc_pkg::MODE_CLOSE: v[i] <= alert_rgb[i];
          slmc_pkg::MODE_NEAR:  v[i] <= blink_on_new ? alert_rgb[i] : '0;
          default:              v[i] <= flash_rgb[i];
        endcase
      end
    end else if (state == slmc_pkg::ST_CHAN && mul_all_done) begin
      for (int i = 0; i < NUM_CH; i++) begin
        v[i] <= mul_prod[i][22:15];
      end
    end
    if (state == slmc_pkg::ST_BRT && mul_all_done) begin
      br <= slmc_pkg::BR_BASE + mul_prod[0][27:15];
    end
    if (state == slmc_pkg::ST_GAMMA && mul_all_done) begin
      for (int i = 0; i < NUM_CH; i++) begin
        duty[i] <= gsum[i][15:8];
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      slmc_pkg::ST_IDLE: begin
        if (tick) begin
          unique case (mode)
            slmc_pkg::MODE_IDLE:  state_next = slmc_pkg::ST_DIV;
            slmc_pkg::MODE_FLASH: state_next = flash_expired ? slmc_pkg::ST_IDLE
                                                             : slmc_pkg::ST_GAMMA;
            default:              state_next = slmc_pkg::ST_GAMMA;
          endcase
        end
      end
      slmc_pkg::ST_DIV:   if (div_done) state_next = slmc_pkg::ST_BRT;
      slmc_pkg::ST_BRT:   if (mul_all_done) state_next = slmc_pkg::ST_CHAN;
      slmc_pkg::ST_CHAN:  if (mul_all_done) state_next = slmc_pkg::ST_GAMMA;
      slmc_pkg::ST_GAMMA: if (mul_all_done) state_next = slmc_pkg::ST_EMIT;
      slmc_pkg::ST_EMIT:  if (!m_tvalid || m_tready) state_next = slmc_pkg::ST_IDLE;
      default:            state_next = slmc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready  = (state == slmc_pkg::ST_IDLE);
    out_load  = (state == slmc_pkg::ST_EMIT) && (!m_tvalid || m_tready);
    mul_start = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      mul_a[i] = '0;
      mul_b[i] = '0;
    end
    unique case (state)
      slmc_pkg::ST_BRT: begin
        mul_start = launch;
        for (int i = 0; i < NUM_CH; i++) begin
          mul_a[i] = biased;
          mul_b[i] = slmc_pkg::BR_GAIN;
        end
      end
      slmc_pkg::ST_CHAN: begin
        mul_start = launch;
        for (int i = 0; i < NUM_CH; i++) begin
          mul_a[i] = AW'(br);
          mul_b[i] = BW'(node_rgb[i]);
        end
      end
      slmc_pkg::ST_GAMMA: begin
        mul_start = launch;
        for (int i = 0; i < NUM_CH; i++) begin
          mul_a[i] = AW'(v[i]);
          mul_b[i] = BW'(v[i]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= slmc_pkg::ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      // start the shared units on the first cycle of each stage
      launch <= (state_next != state);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {duty[2], duty[1], duty[0]};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  slmc_div #(
    .PERIOD(BREATH_PERIOD_MS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (now),
    .done     (div_done),
    .idx      (idx)
  );

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    slmc_mul u_mul (
      .clk   (clk),
      .rst   (rst),
      .start (mul_start),
      .a     (mul_a[g]),
      .b     (mul_b[g]),
      .done  (mul_done[g]),
      .prod  (mul_prod[g])
    );
  end

  a_div_in_stage: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == slmc_pkg::ST_DIV)
    else $error("divider finished outside its stage");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    mul_done[0] == mul_done[1] && mul_done[1] == mul_done[2])
    else $error("multiplier lanes out of step");

  a_br_range: assert property (@(posedge clk) disable iff (rst)
    state == slmc_pkg::ST_CHAN |-> br >= slmc_pkg::BR_BASE)
    else $error("brightness below its floor");

  a_half_range: assert property (@(posedge clk) disable iff (rst)
    half >= slmc_pkg::HALF_MIN && half <= slmc_pkg::HALF_MAX)
    else $error("blink half-period out of range");

  a_emit_load: assert property (@(posedge clk) disable iff (rst)
    state == slmc_pkg::ST_EMIT && !m_tvalid |=> m_tvalid && state == slmc_pkg::ST_IDLE)
    else $error("finished item not moved to the output register");

endmodule

`default_nettype wire

// ===== tb/sv/led_duty_checker.sv =====
`timescale 1ns / 100ps
// Checker for the status LED mode controller: tracks the mode and predicts every duty item.
module led_duty_checker #(
  parameter int unsigned BREATH_PERIOD_MS = slmc_pkg::BREATH_PERIOD_MS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [slmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slmc_pkg::CH_W-1:0]      cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [71:0]                    s_tdata,
  input  logic [1:0]                     s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [23:0]                    m_tdata,
  output int                             duty_errors,
  output int                             duty_waiting
);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } duty_t;

  duty_t           duty_expected[$];
  logic [15:0]     sine_tab [0:16];
  logic [7:0]      color_reg [0:5];
  logic [7:0]      flash_rgb [0:2];
  slmc_pkg::mode_t led_mode;
  logic [31:0]     flash_since;
  logic [31:0]     blink_since;
  logic            blink_on;
  logic [9:0]      blink_half;

  initial begin
    sine_tab[0]  = 16'd0;     sine_tab[1]  = 16'd3212;  sine_tab[2]  = 16'd6393;
    sine_tab[3]  = 16'd9512;  sine_tab[4]  = 16'd12540; sine_tab[5]  = 16'd15447;
    sine_tab[6]  = 16'd18205; sine_tab[7]  = 16'd20788; sine_tab[8]  = 16'd23170;
    sine_tab[9]  = 16'd25330; sine_tab[10] = 16'd27246; sine_tab[11] = 16'd28899;
    sine_tab[12] = 16'd30274; sine_tab[13] = 16'd31357; sine_tab[14] = 16'd32138;
    sine_tab[15] = 16'd32610; sine_tab[16] = 16'd32767;
  end

  function automatic logic [7:0] gamma8(input logic [7:0] v);
    logic [15:0] sq;
    sq = 16'(v) * 16'(v);
    return 8'(sq / 16'd255);
  endfunction

  function automatic duty_t shade(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    duty_t d;
    d.red   = gamma8(r);
    d.green = gamma8(g);
    d.blue  = gamma8(b);
    return d;
  endfunction

  // Closer than 300 cm shortens the half-period, saturating at 100 cm.
  function automatic logic [9:0] blink_half_of(input logic [13:0] dq);
    logic [12:0] x;
    logic [16:0] t;
    if (dq >= 14'd4800) begin
      x = '0;
    end else if (14'd4800 - dq > 14'd3200) begin
      x = 13'd3200;
    end else begin
      x = 13'(14'd4800 - dq);
    end
    t = 17'(x) * 17'd11 + 17'd63;
    return 10'(17'd600 - (t >> 6));
  endfunction

  // Breathing brightness in Q1.15, 0.15 +/- 0.1 from the quarter-wave table.
  function automatic logic [12:0] breath_gain(input logic [31:0] t);
    logic [31:0] p;
    logic [5:0]  idx;
    logic [15:0] mag;
    logic [16:0] biased;
    logic [31:0] u;
    p      = t % BREATH_PERIOD_MS;
    idx    = 6'((64'(p) * 64'd64) / 64'(BREATH_PERIOD_MS));
    mag    = idx[4] ? sine_tab[16 - idx[3:0]] : sine_tab[idx[3:0]];
    biased = idx[5] ? 17'd32768 - 17'(mag) : 17'd32768 + 17'(mag);
    u      = (32'(biased) * 32'd3277) >> 15;
    return 13'(32'd4915 + u - 32'd3277);
  endfunction

  function automatic logic [7:0] scaled(input logic [7:0] c, input logic [12:0] gain);
    return 8'((21'(c) * 21'(gain)) >> 15);
  endfunction

  task automatic predict_duty(input logic [1:0] op, input logic [71:0] d);
    logic [31:0] now;
    logic [12:0] gain;
    now = d[31:0];
    case (op)
      slmc_pkg::OP_FLASH: begin
        if (led_mode == slmc_pkg::MODE_IDLE || led_mode == slmc_pkg::MODE_FLASH) begin
          flash_rgb[0] = d[39:32];
          flash_rgb[1] = d[47:40];
          flash_rgb[2] = d[55:48];
          flash_since  = now;
          led_mode     = slmc_pkg::MODE_FLASH;
        end
      end
      slmc_pkg::OP_RADAR: begin
        if (d[57:56] == slmc_pkg::LVL_CLOSE) begin
          led_mode = slmc_pkg::MODE_CLOSE;
        end else if (d[57:56] == slmc_pkg::LVL_NEAR) begin
          if (led_mode != slmc_pkg::MODE_NEAR) begin
            blink_since = now;
            blink_on    = 1'b1;
            led_mode    = slmc_pkg::MODE_NEAR;
          end
          blink_half = blink_half_of(d[71:58]);
        end else if (led_mode == slmc_pkg::MODE_NEAR || led_mode == slmc_pkg::MODE_CLOSE) begin
          led_mode = slmc_pkg::MODE_IDLE;
        end
      end
      slmc_pkg::OP_TICK: begin
        case (led_mode)
          slmc_pkg::MODE_CLOSE: begin
            duty_expected.push_back(shade(color_reg[slmc_pkg::REG_ALERT_RED],
                                          color_reg[slmc_pkg::REG_ALERT_GREEN],
                                          color_reg[slmc_pkg::REG_ALERT_BLUE]));
          end
          slmc_pkg::MODE_NEAR: begin
            if (now - blink_since >= 32'(blink_half)) begin
              blink_on    = !blink_on;
              blink_since = now;
            end
            if (blink_on) begin
              duty_expected.push_back(shade(color_reg[slmc_pkg::REG_ALERT_RED],
                                            color_reg[slmc_pkg::REG_ALERT_GREEN],
                                            color_reg[slmc_pkg::REG_ALERT_BLUE]));
            end else begin
              duty_expected.push_back(shade(8'd0, 8'd0, 8'd0));
            end
          end
          slmc_pkg::MODE_FLASH: begin
            // expired flash drops to idle and shows nothing this tick
            if (now - flash_since >= slmc_pkg::FLASH_MS) begin
              led_mode = slmc_pkg::MODE_IDLE;
            end else begin
              duty_expected.push_back(shade(flash_rgb[0], flash_rgb[1], flash_rgb[2]));
            end
          end
          default: begin
            gain = breath_gain(now);
            duty_expected.push_back(shade(scaled(color_reg[slmc_pkg::REG_NODE_RED], gain),
                                          scaled(color_reg[slmc_pkg::REG_NODE_GREEN], gain),
                                          scaled(color_reg[slmc_pkg::REG_NODE_BLUE], gain)));
          end
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic note_fault(input string what, input duty_t want, input duty_t got);
    duty_errors++;
    if (duty_errors <= 10) begin
      $display("%0t: %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", $realtime,
               what, want.red, want.green, want.blue, got.red, got.green, got.blue);
    end
  endtask

  always @(posedge clk) begin : track
    duty_t want;
    duty_t got;
    if (rst) begin
      color_reg[slmc_pkg::REG_NODE_RED]    = 8'd0;
      color_reg[slmc_pkg::REG_NODE_GREEN]  = 8'd255;
      color_reg[slmc_pkg::REG_NODE_BLUE]   = 8'd128;
      color_reg[slmc_pkg::REG_ALERT_RED]   = 8'd255;
      color_reg[slmc_pkg::REG_ALERT_GREEN] = 8'd0;
      color_reg[slmc_pkg::REG_ALERT_BLUE]  = 8'd0;
      flash_rgb[0] = 8'd0;
      flash_rgb[1] = 8'd255;
      flash_rgb[2] = 8'd128;
      led_mode     = slmc_pkg::MODE_IDLE;
      flash_since  = '0;
      blink_since  = '0;
      blink_on     = 1'b0;
      blink_half   = slmc_pkg::HALF_MAX;
      duty_expected.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = duty_t'(m_tdata);
        if (duty_expected.size() == 0) begin
          note_fault("unexpected duty item", '0, got);
        end else begin
          want = duty_expected.pop_front();
          if (want.red !== got.red || want.green !== got.green || want.blue !== got.blue) begin
            note_fault("duty mismatch", want, got);
          end
        end
      end
      if (cfg_we && cfg_index <= slmc_pkg::REG_ALERT_BLUE) begin
        color_reg[cfg_index] = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        predict_duty(s_tuser, s_tdata);
      end
    end
    duty_waiting = duty_expected.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the status LED mode controller testbench: stimulus, handshake pacing and verdict.
module testbench;

  localparam int unsigned CFG_IDX_W = slmc_pkg::CFG_IDX_W;
  localparam int unsigned CH_W      = slmc_pkg::CH_W;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] LVL_CLEAR  = 2'd0;
  localparam logic [1:0] LVL_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  localparam int STALL_MAX      = 11;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 230;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CH_W-1:0]      cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic [71:0]          s_tdata   = '0;
  logic [1:0]           s_tuser   = '0;
  logic                 m_tready  = 1'b0;
  wire                  s_tready;
  wire                  m_tvalid;
  wire  [23:0]          m_tdata;

  int          duty_errors;
  int          duty_waiting;
  int          stall_left  = 0;
  int          quiet_cycles = 0;
  bit          steady      = 1'b0;
  logic [31:0] clock_ms    = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  status_led_mode_controller DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  led_duty_checker duty_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .duty_errors (duty_errors),
    .duty_waiting(duty_waiting)
  );

  // Result side: after each item hold tready low for a random stall, none in steady runs.
  always @(posedge clk) begin : take_results
    int n;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      n = steady ? 0 : $urandom_range(0, STALL_MAX);
      m_tready   <= (n == 0);
      stall_left <= n;
    end else if (stall_left != 0) begin
      m_tready   <= (stall_left == 1);
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fields an operation does not use carry random bits.
  function automatic logic [71:0] noisy_word(input logic [31:0] now);
    return {14'($urandom), 2'($urandom), 24'($urandom), now};
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [71:0] word);
    int gap;
    gap = steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_tick(input logic [31:0] now);
    push_item(slmc_pkg::OP_TICK, noisy_word(now));
  endtask

  task automatic send_flash(input logic [31:0] now, input logic [23:0] rgb);
    logic [71:0] w;
    w = noisy_word(now);
    w[55:32] = {rgb[7:0], rgb[15:8], rgb[23:16]};
    push_item(slmc_pkg::OP_FLASH, w);
  endtask

  task automatic send_radar(input logic [31:0] now, input logic [1:0] lvl,
                            input logic [13:0] distance);
    logic [71:0] w;
    w = noisy_word(now);
    w[57:56] = lvl;
    w[71:58] = distance;
    push_item(slmc_pkg::OP_RADAR, w);
  endtask

  // Stop sending, wait for every expected item, then let the block go quiet.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (duty_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_colors(input logic [7:0] nr, input logic [7:0] ng, input logic [7:0] nb,
                            input logic [7:0] ar, input logic [7:0] ag, input logic [7:0] ab);
    write_reg(slmc_pkg::REG_NODE_RED, nr);
    write_reg(slmc_pkg::REG_NODE_GREEN, ng);
    write_reg(slmc_pkg::REG_NODE_BLUE, nb);
    write_reg(slmc_pkg::REG_ALERT_RED, ar);
    write_reg(slmc_pkg::REG_ALERT_GREEN, ag);
    write_reg(slmc_pkg::REG_ALERT_BLUE, ab);
    // spare indexes must be ignored
    write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 1)), 8'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int          k;
    logic [13:0] distance;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        clock_ms = clock_ms + $urandom_range(0, 40);
      end else if (k < 90) begin
        clock_ms = clock_ms + $urandom_range(0, 700);
      end else if (k < 97) begin
        clock_ms = clock_ms + $urandom_range(0, 4000);
      end else if ($urandom_range(0, 1) == 0) begin
        clock_ms = $urandom;
      end else begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      end
      distance = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(1400, 5000))
                                             : 14'($urandom);
      k = $urandom_range(0, 99);
      if (k < 62) begin
        send_tick(clock_ms);
      end else if (k < 74) begin
        send_flash(clock_ms, 24'($urandom));
      end else if (k < 96) begin
        send_radar(clock_ms, 2'($urandom_range(0, 3)), distance);
      end else begin
        push_item(OP_UNUSED, {$urandom, $urandom, 8'($urandom)});
      end
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // breathing at the quadrant edges and the ends of the time range
    send_tick(32'd0);
    send_tick(32'd749);
    send_tick(32'd750);
    send_tick(32'd2250);
    send_tick(32'd2999);
    send_tick(32'hFFFF_FFFF);
    // flash, restart, expiry, expiry across the time wrap
    send_flash(32'd100, 24'hFFFFFF);
    send_tick(32'd399);
    send_flash(32'd200, 24'h000000);
    send_tick(32'd499);
    send_tick(32'd500);
    send_tick(32'd501);
    send_flash(32'hFFFF_FF00, 24'hA55AC3);
    send_tick(32'h0000_002B);
    send_tick(32'h0000_002C);
    // near blink, flash ignored, a repeated near update keeps the phase
    send_radar(32'd1000, slmc_pkg::LVL_NEAR, 14'h3FFF);
    send_flash(32'd1001, 24'h123456);
    send_tick(32'd1599);
    send_tick(32'd1600);
    send_radar(32'd1610, slmc_pkg::LVL_NEAR, 14'd0);
    send_tick(32'd1660);
    send_radar(32'd1700, slmc_pkg::LVL_NEAR, 14'd3000);
    // close, flash ignored, unused level clears
    send_radar(32'd1800, slmc_pkg::LVL_CLOSE, 14'd4799);
    send_tick(32'd1801);
    send_flash(32'd1802, 24'hFFFFFF);
    send_radar(32'd1803, LVL_UNUSED, 14'd0);
    send_tick(32'd1804);
    send_radar(32'd1805, slmc_pkg::LVL_NEAR, 14'd4800);
    send_radar(32'd1806, LVL_CLEAR, 14'd0);
    push_item(OP_UNUSED, {$urandom, $urandom, 8'($urandom)});
    send_tick(32'd1807);
    drain();

    clock_ms = $urandom;
    set_colors(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(PHASE_ITEMS);
    drain();
    set_colors(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_random(PHASE_ITEMS);
    drain();
    set_colors(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    steady = 1'b1;
    run_random(PHASE_ITEMS);
    drain();
    steady = 1'b0;
    set_colors(8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom));
    run_random(PHASE_ITEMS);
    drain();
    set_colors(8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom));
    run_random(PHASE_ITEMS);
    drain();

    if (duty_errors == 0 && duty_waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
